// ===== rtl/interval_coverage_profile_assert.svh =====
// Assertion macros for the coverage profile block.
// The clock and reset are taken from the module scope (clk, rst_n).
`ifndef INTERVAL_COVERAGE_PROFILE_ASSERT_SVH
`define INTERVAL_COVERAGE_PROFILE_ASSERT_SVH

// Consequent checked in the same cycle.
`define ICP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the next cycle.
`define ICP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/icp_pkg.sv =====
`default_nettype none

package icp_pkg;

  localparam int MAX_SEGMENTS = 32;
  localparam int SEG_AW       = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 3);
  localparam int MEM_DEPTH    = 2 ** (SEG_AW + 1);
  localparam int DATA_W       = 32;
  localparam int CFG_AW       = 1;

  localparam logic [CFG_AW-1:0] REG_REGION_BEGIN = 1'd0;
  localparam logic [CFG_AW-1:0] REG_REGION_LIMIT = 1'd1;

  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] seg_level;
    logic [DATA_W-1:0] seg_end;
    logic [DATA_W-1:0] seg_start;
  } seg_t;

endpackage

`default_nettype wire

// ===== rtl/interval_coverage_profile.sv =====
// Coverage profile over half-open segments [start, end), up to MAX_SEGMENTS of them,
// kept in one segment memory split into two banks. An add transaction (tuser 0) raises
// the level over [add_start, add_end) with saturation; a clear transaction (tuser 1)
// resets the list to one level-zero segment over the configured region. After every
// transaction the whole list is sent out, one output transaction per segment, tlast on
// the final one. An add rebuilds the list into the idle bank, producing one piece per
// cycle and reading the next old segment once the current one is done; splitting adds
// up to 2 pieces. A clear or an empty range skips the rebuild. The output reads one
// segment per cycle from the memory read port while out_tready is high. One transaction
// is in flight at a time. After reset the block writes the initial segment before
// in_tready rises.
`default_nettype none
`include "interval_coverage_profile_assert.svh"

module interval_coverage_profile
  import icp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [3*DATA_W-1:0] in_tdata,   // add_start, add_end, add_level
  input  logic                in_tuser,   // mode
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [3*DATA_W-1:0] out_tdata,  // seg_start, seg_end, seg_level
  output logic                out_tlast,
  output logic [1:0]          out_tuser,  // overflow, saturated
  input  logic                cfg_wr_en,
  input  logic [CFG_AW-1:0]   cfg_addr,
  input  logic [DATA_W-1:0]   cfg_wdata
);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_BUILD, S_DRAIN, S_FLUSH, S_LOAD, S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_FIRST, PH_INSIDE, PH_AFTER
  } phase_t;

  logic [DATA_W-1:0] region_begin_r, region_limit_r;

  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic              bank_r, bank_nxt;
  logic [CNT_W-1:0]  seg_count_r, seg_count_nxt;
  logic [CNT_W-1:0]  seg_idx_r, seg_idx_nxt;
  logic [CNT_W-1:0]  wr_cnt_r, wr_cnt_nxt;
  logic [CNT_W-1:0]  emit_idx_r, emit_idx_nxt;
  logic              piece_v_r, piece_v_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic              ovf_r, ovf_nxt;
  logic              sat_r, sat_nxt;
  logic              out_tvalid_r, out_tvalid_nxt;
  seg_t              piece_r, piece_nxt;
  seg_t              pend_r, pend_nxt;
  logic [DATA_W-1:0] add_start_r, add_start_nxt;
  logic [DATA_W-1:0] add_end_r, add_end_nxt;
  logic [DATA_W-1:0] add_level_r, add_level_nxt;

  seg_t              mem [MEM_DEPTH];
  seg_t              rdata_r;
  logic              rd_en;
  logic [SEG_AW:0]   rd_addr;
  logic              mem_we;
  logic [SEG_AW:0]   mem_waddr;
  seg_t              mem_wdata;

  logic              ovl, has_before, has_after;
  logic [DATA_W:0]   sum;
  seg_t              mid_seg, gen;
  logic              gen_done, gen_inside;
  phase_t            gen_phase;
  logic              merge_we;
  logic [CNT_W-1:0]  seg_idx_inc, emit_idx_inc;
  logic              in_fire;

  assign in_fire      = in_tvalid && in_tready;
  assign seg_idx_inc  = seg_idx_r + CNT_W'(1);
  assign emit_idx_inc = emit_idx_r + CNT_W'(1);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_begin_r <= '0;
      region_limit_r <= '1;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_REGION_BEGIN: region_begin_r <= cfg_wdata;
        REG_REGION_LIMIT: region_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Piece generator for the segment held in rdata_r.
  always_comb begin
    ovl        = (rdata_r.seg_start < rdata_r.seg_end) &&
                 (rdata_r.seg_end > add_start_r) && (rdata_r.seg_start < add_end_r);
    has_before = add_start_r > rdata_r.seg_start;
    has_after  = add_end_r < rdata_r.seg_end;
    sum        = {1'b0, rdata_r.seg_level} + {1'b0, add_level_r};

    mid_seg.seg_start = has_before ? add_start_r : rdata_r.seg_start;
    mid_seg.seg_end   = has_after ? add_end_r : rdata_r.seg_end;
    mid_seg.seg_level = sum[DATA_W] ? '1 : sum[DATA_W-1:0];

    gen        = rdata_r;
    gen_done   = 1'b1;
    gen_inside = 1'b0;
    gen_phase  = PH_FIRST;
    if (ovl) begin
      case (phase_r)
        PH_FIRST: begin
          if (has_before) begin
            gen.seg_end = add_start_r;
            gen_done    = 1'b0;
            gen_phase   = PH_INSIDE;
          end else begin
            gen        = mid_seg;
            gen_inside = 1'b1;
            gen_done   = !has_after;
            gen_phase  = has_after ? PH_AFTER : PH_FIRST;
          end
        end
        PH_INSIDE: begin
          gen        = mid_seg;
          gen_inside = 1'b1;
          gen_done   = !has_after;
          gen_phase  = has_after ? PH_AFTER : PH_FIRST;
        end
        PH_AFTER: begin
          gen.seg_start = add_end_r;
        end
        default: ;
      endcase
    end
  end

  assign merge_we = piece_v_r && pend_v_r && (piece_r.seg_level != pend_r.seg_level) &&
                    (wr_cnt_r < CNT_W'(MAX_SEGMENTS));

  // Memory write port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {~bank_r, wr_cnt_r[SEG_AW-1:0]};
    mem_wdata = pend_r;
    case (state_r)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = '{seg_level: '0, seg_end: '1, seg_start: '0};
      end
      S_IDLE: begin
        mem_we    = in_fire && (in_tuser == MODE_CLEAR);
        mem_waddr = {bank_r, {SEG_AW{1'b0}}};
        mem_wdata = '{seg_level: '0, seg_end: region_limit_r, seg_start: region_begin_r};
      end
      S_FLUSH: mem_we = wr_cnt_r < CNT_W'(MAX_SEGMENTS);
      default: mem_we = merge_we;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (rd_en) rdata_r <= mem[rd_addr];
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    bank_nxt       = bank_r;
    seg_count_nxt  = seg_count_r;
    seg_idx_nxt    = seg_idx_r;
    wr_cnt_nxt     = wr_cnt_r;
    emit_idx_nxt   = emit_idx_r;
    piece_v_nxt    = 1'b0;
    piece_nxt      = piece_r;
    pend_v_nxt     = pend_v_r;
    pend_nxt       = pend_r;
    ovf_nxt        = ovf_r;
    sat_nxt        = sat_r;
    out_tvalid_nxt = out_tvalid_r;
    add_start_nxt  = add_start_r;
    add_end_nxt    = add_end_r;
    add_level_nxt  = add_level_r;
    rd_en          = 1'b0;
    rd_addr        = {bank_r, seg_idx_r[SEG_AW-1:0]};

    // merge the registered piece into the pending segment
    if (piece_v_r) begin
      if (!pend_v_r) begin
        pend_nxt   = piece_r;
        pend_v_nxt = 1'b1;
      end else if (piece_r.seg_level == pend_r.seg_level) begin
        pend_nxt.seg_end = piece_r.seg_end;
      end else begin
        pend_nxt   = piece_r;
        wr_cnt_nxt = wr_cnt_r + CNT_W'(1);
      end
    end

    case (state_r)
      S_INIT: state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_tvalid) begin
          ovf_nxt       = 1'b0;
          sat_nxt       = 1'b0;
          add_start_nxt = in_tdata[DATA_W-1:0];
          add_end_nxt   = in_tdata[2*DATA_W-1:DATA_W];
          add_level_nxt = in_tdata[3*DATA_W-1:2*DATA_W];
          if (in_tuser == MODE_CLEAR) begin
            seg_count_nxt = CNT_W'(1);
            state_nxt     = S_LOAD;
          end else if (in_tdata[DATA_W-1:0] < in_tdata[2*DATA_W-1:DATA_W]) begin
            rd_en       = 1'b1;
            rd_addr     = {bank_r, {SEG_AW{1'b0}}};
            seg_idx_nxt = '0;
            phase_nxt   = PH_FIRST;
            pend_v_nxt  = 1'b0;
            wr_cnt_nxt  = '0;
            state_nxt   = S_BUILD;
          end else begin
            state_nxt = S_LOAD;
          end
        end
      end
      S_BUILD: begin
        piece_v_nxt = 1'b1;
        piece_nxt   = gen;
        phase_nxt   = gen_phase;
        if (gen_inside && sum[DATA_W]) sat_nxt = 1'b1;
        if (gen_done) begin
          if (seg_idx_inc < seg_count_r) begin
            rd_en       = 1'b1;
            rd_addr     = {bank_r, seg_idx_inc[SEG_AW-1:0]};
            seg_idx_nxt = seg_idx_inc;
          end else begin
            state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: state_nxt = S_FLUSH;
      S_FLUSH: begin
        if (wr_cnt_r >= CNT_W'(MAX_SEGMENTS)) begin
          ovf_nxt = 1'b1;
          sat_nxt = 1'b0;
        end else begin
          bank_nxt      = ~bank_r;
          seg_count_nxt = wr_cnt_r + CNT_W'(1);
        end
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        rd_en          = 1'b1;
        rd_addr        = {bank_r, {SEG_AW{1'b0}}};
        emit_idx_nxt   = '0;
        out_tvalid_nxt = 1'b1;
        state_nxt      = S_EMIT;
      end
      S_EMIT: begin
        if (out_tready) begin
          if (emit_idx_inc == seg_count_r) begin
            out_tvalid_nxt = 1'b0;
            state_nxt      = S_IDLE;
          end else begin
            rd_en        = 1'b1;
            rd_addr      = {bank_r, emit_idx_inc[SEG_AW-1:0]};
            emit_idx_nxt = emit_idx_inc;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      phase_r      <= PH_FIRST;
      bank_r       <= 1'b0;
      seg_count_r  <= CNT_W'(1);
      seg_idx_r    <= '0;
      wr_cnt_r     <= '0;
      emit_idx_r   <= '0;
      piece_v_r    <= 1'b0;
      pend_v_r     <= 1'b0;
      ovf_r        <= 1'b0;
      sat_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      bank_r       <= bank_nxt;
      seg_count_r  <= seg_count_nxt;
      seg_idx_r    <= seg_idx_nxt;
      wr_cnt_r     <= wr_cnt_nxt;
      emit_idx_r   <= emit_idx_nxt;
      piece_v_r    <= piece_v_nxt;
      pend_v_r     <= pend_v_nxt;
      ovf_r        <= ovf_nxt;
      sat_r        <= sat_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    piece_r     <= piece_nxt;
    pend_r      <= pend_nxt;
    add_start_r <= add_start_nxt;
    add_end_r   <= add_end_nxt;
    add_level_r <= add_level_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = rdata_r;
  assign out_tlast  = (emit_idx_r == seg_count_r - CNT_W'(1));
  assign out_tuser  = {sat_r, ovf_r};

  `ICP_ASSERT_SAME(a_count_range, state_r != S_INIT,
    (seg_count_r != '0) && (seg_count_r <= CNT_W'(MAX_SEGMENTS)), "segment count out of range")
  `ICP_ASSERT_SAME(a_flags_excl, out_tvalid_r, !(ovf_r && sat_r),
    "overflow and saturated both set")
  `ICP_ASSERT_SAME(a_wr_in_bank, mem_we, int'(mem_waddr[SEG_AW-1:0]) < MAX_SEGMENTS,
    "segment write beyond capacity")
  `ICP_ASSERT_NEXT(a_emit_cont, out_tvalid_r && out_tready && !out_tlast, out_tvalid_r,
    "list output stopped before last segment")
  `ICP_ASSERT_SAME(a_idle_clean, in_tvalid && in_tready, !out_tvalid_r && !piece_v_r,
    "input accepted while a transaction is in progress")

endmodule

`default_nettype wire
